@@ sv/rmt_pkg.sv @@
// Ring marker tachometer package: payload structs, controller/datapath
// command and status structs, arithmetic constants and status codes.
// No dependencies.
package rmt_pkg;

    typedef struct packed {
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [12:0] pixel_angle;
        logic [31:0] frame_time_ms;
        logic        frame_end;
    } t_rmt_in;

    typedef struct packed {
        logic [23:0] rpm_x16;
        logic [1:0]  status;
    } t_rmt_out;

    typedef struct packed {
        logic pix;
        logic push;
        logic read;
        logic mul;
        logic div;
        logic load;
    } t_rmt_cmd;

    typedef struct packed {
        logic found;
        logic sum_done;
        logic div_done;
    } t_rmt_sts;

    localparam logic [1:0]  STS_OK    = 2'd0;
    localparam logic [1:0]  STS_SHORT = 2'd1;
    localparam logic [1:0]  STS_ZERO  = 2'd2;

    localparam logic [12:0] ANGLE_MAX = 13'd5759;
    localparam logic [12:0] FULL_TURN = 13'd5760;
    localparam logic [23:0] RPM_MAX   = 24'hFFFFFF;

    localparam logic [15:0] LUMA_WR = 16'd77;
    localparam logic [15:0] LUMA_WG = 16'd150;
    localparam logic [15:0] LUMA_WB = 16'd29;

    // 60000 / 360 reduced by 120
    localparam int RPM_NUM = 500;
    localparam int SPAN_W  = 34;

endpackage

@@ sv/rmt_ctrl.sv @@
// Ring marker tachometer controller: sequences pixel intake, history push,
// history sweep, scaling multiply, divide and result load. Depends on rmt_pkg.
module rmt_ctrl import rmt_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  logic     i_in_frame_end,
    input  logic     i_out_ready,
    input  t_rmt_sts i_sts,
    output t_rmt_cmd o_cmd,
    output logic     o_in_ready,
    output logic     o_out_valid
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_PUSH,
        S_READ,
        S_MUL,
        S_DIV,
        S_LOAD
    } t_state;

    t_state r_state;
    logic   r_out_valid;
    logic   in_acc;
    logic   slot_free;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign in_acc      = i_in_valid && (r_state == S_IDLE);
    assign slot_free   = !r_out_valid || i_out_ready;

    always_comb begin
        o_cmd      = '0;
        o_cmd.pix  = in_acc;
        o_cmd.push = (r_state == S_PUSH);
        o_cmd.read = (r_state == S_READ);
        o_cmd.mul  = (r_state == S_MUL);
        o_cmd.div  = (r_state == S_DIV);
        o_cmd.load = (r_state == S_LOAD) && slot_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (o_cmd.load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc && i_in_frame_end) begin
                        r_state <= S_PUSH;
                    end
                end
                S_PUSH: begin
                    r_state <= i_sts.found ? S_READ : S_IDLE;
                end
                S_READ: begin
                    if (i_sts.sum_done) begin
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (i_sts.div_done) begin
                        r_state <= S_LOAD;
                    end
                end
                S_LOAD: begin
                    if (slot_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

@@ sv/rmt_dp.sv @@
// Ring marker tachometer datapath: luma test, min/max trackers, position
// history memory, step sum, bit-serial divider and result register.
// Depends on rmt_pkg.
module rmt_dp import rmt_pkg::*; #(
    parameter int QUEUE_LIMIT = 5
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_rmt_cmd    i_cmd,
    output t_rmt_sts    o_sts,
    input  t_rmt_in     i_pix,
    input  logic        i_clockwise,
    input  logic [7:0]  i_luma_threshold,
    output t_rmt_out    o_result
);

    localparam int DEPTH  = QUEUE_LIMIT + 1;
    localparam int AW     = $clog2(DEPTH);
    localparam int CW     = $clog2(DEPTH + 1);
    localparam int SUM_W  = $clog2(QUEUE_LIMIT * 5760 + 1);
    localparam int DIVD_W = $clog2(QUEUE_LIMIT * 5760 * RPM_NUM + 1);
    localparam int DCW    = $clog2(DIVD_W + 1);
    localparam int QW     = (DIVD_W > 24) ? DIVD_W : 24;

    typedef struct packed {
        logic [12:0] angle;
        logic [31:0] time_ms;
    } t_hist;

    t_hist              r_mem [DEPTH];
    t_hist              r_rd_data;
    logic [12:0]        r_min;
    logic [12:0]        r_max;
    logic               r_found;
    logic [31:0]        r_time;
    logic [AW-1:0]      r_head;
    logic [CW-1:0]      r_count;
    logic [CW-1:0]      r_k;
    logic               r_rd_vld;
    logic               r_first;
    logic [12:0]        r_prev_angle;
    logic [SUM_W-1:0]   r_sum;
    logic [31:0]        r_oldest_time;
    logic [DIVD_W-1:0]  r_quo;
    logic [SPAN_W-1:0]  r_rem;
    logic [SPAN_W-1:0]  r_divisor;
    logic [DCW-1:0]     r_div_cnt;
    logic [1:0]         r_code;
    t_rmt_out           r_out;

    logic [15:0]        luma_sum;
    logic               qual;
    logic [12:0]        angle_sat;
    logic [13:0]        mid_sum;
    logic               full;
    logic [AW-1:0]      wr_idx;
    logic [AW-1:0]      rd_addr;
    logic               rd_en;
    logic [12:0]        step;
    logic [31:0]        span;
    logic [1:0]         code;
    logic [SPAN_W:0]    trial;
    logic               take;
    logic [QW-1:0]      q_ext;
    logic [23:0]        rpm_sat;

    function automatic logic [AW-1:0] slot(input logic [AW-1:0] head, input logic [CW-1:0] k);
        logic [CW:0] s;
        s = {1'b0, CW'(head)} + {1'b0, k};
        if (s >= (CW + 1)'(DEPTH)) begin
            s = s - (CW + 1)'(DEPTH);
        end
        return s[AW-1:0];
    endfunction

    function automatic logic [12:0] wrap_step(input logic [12:0] older, input logic [12:0] newer,
                                              input logic cw);
        logic [12:0] d;
        logic [12:0] res;
        res = '0;
        if (newer > older) begin
            d   = newer - older;
            res = cw ? d : FULL_TURN - d;
        end else if (newer < older) begin
            d   = older - newer;
            res = cw ? FULL_TURN - d : d;
        end
        return res;
    endfunction

    assign luma_sum  = 16'(i_pix.red) * LUMA_WR + 16'(i_pix.green) * LUMA_WG
                     + 16'(i_pix.blue) * LUMA_WB;
    assign qual      = luma_sum[15:8] > i_luma_threshold;
    assign angle_sat = (i_pix.pixel_angle > ANGLE_MAX) ? ANGLE_MAX : i_pix.pixel_angle;
    assign mid_sum   = {1'b0, r_min} + {1'b0, r_max};
    assign full      = (r_count == CW'(DEPTH));
    assign wr_idx    = full ? r_head : slot(r_head, r_count);
    assign rd_en     = i_cmd.read && (r_k != r_count);
    assign rd_addr   = slot(r_head, r_k);
    assign step      = wrap_step(r_prev_angle, r_rd_data.angle, i_clockwise);
    assign span      = r_time - r_oldest_time;
    assign trial     = {r_rem, r_quo[DIVD_W-1]};
    assign take      = trial >= {1'b0, r_divisor};
    assign q_ext     = QW'(r_quo);
    assign rpm_sat   = (q_ext > QW'(RPM_MAX)) ? RPM_MAX : q_ext[23:0];

    always_comb begin
        if (r_count < CW'(2)) begin
            code = STS_SHORT;
        end else if (span == 32'd0) begin
            code = STS_ZERO;
        end else begin
            code = STS_OK;
        end
    end

    assign o_sts.found    = r_found;
    assign o_sts.sum_done = (r_k == r_count) && !r_rd_vld;
    assign o_sts.div_done = (r_div_cnt == '0);
    assign o_result       = r_out;

    // per-frame trackers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min   <= ANGLE_MAX;
            r_max   <= '0;
            r_found <= 1'b0;
        end else if (i_cmd.push) begin
            r_min   <= ANGLE_MAX;
            r_max   <= '0;
            r_found <= 1'b0;
        end else if (i_cmd.pix && qual) begin
            if (!r_found || angle_sat < r_min) begin
                r_min <= angle_sat;
            end
            if (!r_found || angle_sat > r_max) begin
                r_max <= angle_sat;
            end
            r_found <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.pix) begin
            r_time <= i_pix.frame_time_ms;
        end
    end

    // history memory
    always_ff @(posedge i_clk) begin
        if (i_cmd.push && r_found) begin
            r_mem[wr_idx] <= '{angle: mid_sum[13:1], time_ms: r_time};
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head   <= '0;
            r_count  <= '0;
            r_k      <= '0;
            r_rd_vld <= 1'b0;
            r_first  <= 1'b1;
        end else if (i_cmd.push) begin
            if (r_found) begin
                if (full) begin
                    r_head <= (r_head == AW'(DEPTH - 1)) ? '0 : r_head + AW'(1);
                end else begin
                    r_count <= r_count + CW'(1);
                end
            end
            r_k      <= '0;
            r_rd_vld <= 1'b0;
            r_first  <= 1'b1;
        end else if (i_cmd.read) begin
            if (rd_en) begin
                r_k <= r_k + CW'(1);
            end
            r_rd_vld <= rd_en;
            if (r_rd_vld) begin
                r_first <= 1'b0;
            end
        end
    end

    // step sum over the history
    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_sum <= '0;
        end else if (i_cmd.read && r_rd_vld) begin
            if (r_first) begin
                r_oldest_time <= r_rd_data.time_ms;
            end else begin
                r_sum <= r_sum + SUM_W'(step);
            end
            r_prev_angle <= r_rd_data.angle;
        end
    end

    // scale, then restoring divide one quotient bit per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div_cnt <= '0;
        end else if (i_cmd.mul) begin
            r_div_cnt <= (code == STS_OK) ? DCW'(DIVD_W) : '0;
        end else if (i_cmd.div && r_div_cnt != '0) begin
            r_div_cnt <= r_div_cnt - DCW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul) begin
            r_code    <= code;
            r_quo     <= DIVD_W'(DIVD_W'(r_sum) * DIVD_W'(RPM_NUM));
            r_rem     <= '0;
            r_divisor <= {2'b00, span} + {1'b0, span, 1'b0};
        end else if (i_cmd.div && r_div_cnt != '0) begin
            r_rem <= take ? SPAN_W'(trial - {1'b0, r_divisor}) : trial[SPAN_W-1:0];
            r_quo <= {r_quo[DIVD_W-2:0], take};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_out.status  <= r_code;
            r_out.rpm_x16 <= (r_code == STS_OK) ? rpm_sat : '0;
        end
    end

endmodule

@@ sv/ring_marker_tachometer.sv @@
// Ring marker tachometer top level: APB register file, controller and
// datapath. Depends on rmt_pkg, rmt_ctrl, rmt_dp.
//
// Usage: ring pixels enter on the input valid/ready channel, one
// transaction per pixel, with frame_end set on the last pixel of a frame.
// Ordinary pixels are accepted one per cycle while the block is idle. A
// frame_end pixel starts the per-frame work: push into the position
// history, a sweep of the history memory through its single read port,
// the scaling multiply and a restoring divider that makes one quotient
// bit per cycle (none when the status is not OK), then a load into the
// output register. Input ready is low through this work, including any
// wait in the load step. A frame without a marker pixel returns to idle
// after the push step and gives no result transaction.
// The output register holds one result; new pixels are accepted while it
// waits. If the receiver stalls, the next frame end waits in the load step.
// Reset clears the trackers, the history and the output valid; it sets
// clockwise to 0 and luma_threshold to 200. Registers are written over APB
// at 0x0 (clockwise) and 0x4 (luma_threshold); the user must write them
// only while the block is idle, which the block itself does not enforce.
module ring_marker_tachometer import rmt_pkg::*; #(
    parameter int QUEUE_LIMIT = 5
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_rmt_in     i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_rmt_out    o_out_data,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic       r_clockwise;
    logic [7:0] r_luma_threshold;
    logic       cfg_wr;
    t_rmt_cmd   cmd;
    t_rmt_sts   sts;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign prdata = paddr[2] ? {24'd0, r_luma_threshold} : {31'd0, r_clockwise};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clockwise      <= 1'b0;
            r_luma_threshold <= 8'd200;
        end else if (cfg_wr) begin
            if (paddr[2]) begin
                r_luma_threshold <= pwdata[7:0];
            end else begin
                r_clockwise <= pwdata[0];
            end
        end
    end

    rmt_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .i_in_frame_end (i_in_data.frame_end),
        .i_out_ready    (i_out_ready),
        .i_sts          (sts),
        .o_cmd          (cmd),
        .o_in_ready     (o_in_ready),
        .o_out_valid    (o_out_valid)
    );

    rmt_dp #(
        .QUEUE_LIMIT (QUEUE_LIMIT)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .i_pix            (i_in_data),
        .i_clockwise      (r_clockwise),
        .i_luma_threshold (r_luma_threshold),
        .o_result         (o_out_data)
    );

endmodule
